// ===== rtl/core/btb2l_pkg.sv =====
// Package for the two-level branch predictor with BTB.
// Holds the item and configuration types, the codes and the config helpers.
// No dependencies.
package btb2l_pkg;

    localparam int PC_W      = 32;
    localparam int TAG_MAX   = 30;
    localparam int TGT_BITS  = 30;
    localparam int HIST_KEEP = 8;
    localparam int MID_SHIFT = 16;
    localparam int STOR_W    = 15;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_UPDATE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_MID  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BTB_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR_INIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOB_HIST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOB_TBL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE     = 3'd6;

    typedef struct packed {
        logic [2:0] btb_size_log2;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] counter_init;
        logic       global_history_on;
        logic       global_table_on;
        logic [1:0] share_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic [PC_W-1:0]    pc;
        logic [PC_W-1:0]    target;
        logic               taken;
        logic [PC_W-1:0]    pdst;
        logic [TAG_MAX-1:0] tag;
    } t_item;

    // saturate the BTB size to what the entry array holds
    function automatic logic [3:0] eff_log2(input t_cfg c, input logic [3:0] kmax);
        return ({1'b0, c.btb_size_log2} < kmax) ? {1'b0, c.btb_size_log2} : kmax;
    endfunction

    function automatic logic [3:0] eff_hist(input t_cfg c, input logic [3:0] hmax);
        logic [3:0] h;
        h = c.history_bits;
        if (h == 4'd0) h = 4'd1;
        else if (h > hmax) h = hmax;
        return h;
    endfunction

    function automatic logic [4:0] eff_tag(input t_cfg c);
        return (c.tag_bits > 5'(TAG_MAX)) ? 5'(TAG_MAX) : c.tag_bits;
    endfunction

    function automatic logic [1:0] eff_share(input t_cfg c);
        return (!c.global_table_on || c.share_mode > SHARE_MID) ? SHARE_NONE
                                                                : c.share_mode;
    endfunction

endpackage

// ===== rtl/core/btb2l_front.sv =====
// Front part: takes input items, derives the tag and packs them for the queue.
// Depends on btb2l_pkg.
module btb2l_front import btb2l_pkg::*; #(
    parameter int K_MAX = 5
) (
    input  logic            i_valid,
    input  logic [1:0]      i_mode,
    input  logic [PC_W-1:0] i_branch_pc,
    input  logic [PC_W-1:0] i_actual_target,
    input  logic            i_was_taken,
    input  logic [PC_W-1:0] i_predicted_dest,
    input  t_cfg            i_cfg,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output t_item           o_item
);
    logic [3:0]         k;
    logic [4:0]         et;
    logic [TAG_MAX-1:0] tag_mask;
    logic [PC_W-1:0]    shifted;

    always_comb begin
        k  = eff_log2(i_cfg, 4'(K_MAX));
        et = eff_tag(i_cfg);
        for (int i = 0; i < TAG_MAX; i++) begin
            tag_mask[i] = (i < int'(et));
        end
        shifted = i_branch_pc >> (5'(k) + 5'd2);
    end

    assign o_stall        = i_q_full;
    assign o_push         = i_valid && !i_q_full;
    assign o_item.mode    = i_mode;
    assign o_item.pc      = i_branch_pc;
    assign o_item.target  = i_actual_target;
    assign o_item.taken   = i_was_taken;
    assign o_item.pdst    = i_predicted_dest;
    assign o_item.tag     = shifted[TAG_MAX-1:0] & tag_mask;

endmodule

// ===== rtl/core/btb2l_queue.sv =====
// Two-entry queue between the front and the back part.
// Depends on btb2l_pkg.
module btb2l_queue import btb2l_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/core/btb2l_back.sv =====
// Back part: BTB entries, counter memories, sweeps and the result register.
// Depends on btb2l_pkg.
module btb2l_back import btb2l_pkg::*; #(
    parameter int BTB_DEPTH   = 32,
    parameter int MAX_HISTORY = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_empty,
    input  t_item             i_q_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_predict_taken,
    output logic [PC_W-1:0]   o_next_fetch,
    output logic              o_flushed,
    output logic [PC_W-1:0]   o_branch_count,
    output logic [PC_W-1:0]   o_flush_count,
    output logic [STOR_W-1:0] o_storage_bits
);
    localparam int K_MAX  = $clog2(BTB_DEPTH + 1) - 1;
    localparam int IDX_W  = (K_MAX > 0) ? K_MAX : 1;
    localparam int ENT    = 2 ** IDX_W;
    localparam int ROW    = 2 ** MAX_HISTORY;
    localparam int LOC_AW = IDX_W + MAX_HISTORY;
    localparam int LOC_D  = 2 ** LOC_AW;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_ADDR  = 3'd4;
    localparam logic [2:0] S_CTR   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]         r_state;
    logic [LOC_AW-1:0]  r_sweep;
    logic               r_emit;
    t_item              r_it;
    logic [IDX_W-1:0]   r_idx;
    logic [ENT-1:0]     r_valid;
    logic               r_e_valid;
    logic [TAG_MAX-1:0] r_e_tag;
    logic [PC_W-1:0]    r_e_tgt;
    logic [HIST_KEEP-1:0] r_e_hist;
    logic [HIST_KEEP-1:0] r_sh_hist;
    logic [PC_W-1:0]    r_branches;
    logic [PC_W-1:0]    r_flushes;
    logic               r_ptk;
    logic [PC_W-1:0]    r_nf;
    logic               r_fl;
    logic [1:0]         r_loc_q;
    logic [1:0]         r_sh_q;

    logic [TAG_MAX-1:0]   m_tag  [ENT];
    logic [PC_W-1:0]      m_tgt  [ENT];
    logic [HIST_KEEP-1:0] m_hist [ENT];
    logic [1:0]           m_loc  [LOC_D];
    logic [1:0]           m_sh   [ROW];

    logic [3:0]           k;
    logic [3:0]           h;
    logic [4:0]           et;
    logic [1:0]           shm;
    logic [IDX_W-1:0]     idx_mask;
    logic [IDX_W-1:0]     head_idx;
    logic [HIST_KEEP-1:0] hmask;
    logic [HIST_KEEP-1:0] hsel;
    logic [HIST_KEEP-1:0] hidx;
    logic [MAX_HISTORY-1:0] ctr_row;
    logic                 is_upd;
    logic                 alloc;
    logic                 hit;
    logic [1:0]           ctr;
    logic [1:0]           trained;
    logic [PC_W-1:0]      pc4;
    logic                 fl;
    logic                 sweep_end;
    logic                 row_end;
    logic                 fin_go;
    logic [LOC_AW-1:0]    loc_addr;
    logic                 loc_we;
    logic [1:0]           loc_wd;
    logic [MAX_HISTORY-1:0] sh_addr;
    logic                 sh_we;
    logic [1:0]           sh_wd;
    logic [IDX_W-1:0]     e_addr;
    logic                 tag_we;
    logic                 tgt_we;
    logic                 hist_we;
    logic [HIST_KEEP-1:0] hist_wd;
    logic [19:0]          stor;

    always_comb begin
        k   = eff_log2(i_cfg, 4'(K_MAX));
        h   = eff_hist(i_cfg, 4'(MAX_HISTORY));
        et  = eff_tag(i_cfg);
        shm = eff_share(i_cfg);
        for (int i = 0; i < IDX_W; i++) idx_mask[i] = (i < int'(k));
        for (int i = 0; i < HIST_KEEP; i++) hmask[i] = (i < int'(h));
        head_idx = i_q_head.pc[2 +: IDX_W] & idx_mask;

        hsel = i_cfg.global_history_on ? r_sh_hist : r_e_hist;
        unique case (shm)
            SHARE_LOW: hsel = hsel ^ r_it.pc[2 +: HIST_KEEP];
            SHARE_MID: hsel = hsel ^ r_it.pc[MID_SHIFT +: HIST_KEEP];
            default:   hsel = hsel;
        endcase
        hidx    = hsel & hmask;
        ctr_row = hidx[MAX_HISTORY-1:0];

        is_upd = (r_it.mode == MODE_UPDATE);
        alloc  = is_upd && (!r_e_valid || (r_e_tag != r_it.tag));
        hit    = r_e_valid && ((et == 5'd0) || (r_e_tag == r_it.tag));
        ctr    = i_cfg.global_table_on ? r_sh_q : r_loc_q;
        if (r_it.taken) trained = (ctr == 2'd3) ? ctr : ctr + 2'd1;
        else            trained = (ctr == 2'd0) ? ctr : ctr - 2'd1;
        pc4 = r_it.pc + 32'd4;
        fl  = r_it.taken ? (r_it.pdst != r_it.target) : (r_it.pdst != pc4);

        sweep_end = (r_sweep == '1);
        row_end   = (r_sweep[MAX_HISTORY-1:0] == '1);
        fin_go    = (r_state == S_FIN) && (!o_out_valid || !i_out_stall);
        o_pop     = (r_state == S_IDLE) && !i_q_empty;

        // counter memories: clear sweep, row refill, read, train
        priority if (r_state == S_CLR)  loc_addr = r_sweep;
        else if (r_state == S_ALLOC)    loc_addr = {r_idx, r_sweep[MAX_HISTORY-1:0]};
        else                            loc_addr = {r_idx, ctr_row};
        loc_we = (r_state == S_CLR) || (r_state == S_ALLOC) ||
                 ((r_state == S_CTR) && is_upd && !i_cfg.global_table_on);
        loc_wd = (r_state == S_CTR) ? trained : i_cfg.counter_init;
        sh_addr = (r_state == S_CLR) ? r_sweep[MAX_HISTORY-1:0] : ctr_row;
        sh_we   = (r_state == S_CLR) ||
                  ((r_state == S_CTR) && is_upd && i_cfg.global_table_on);
        sh_wd   = (r_state == S_CTR) ? trained : i_cfg.counter_init;

        // entry arrays
        e_addr  = (r_state == S_CLR) ? r_sweep[IDX_W-1:0] : r_idx;
        tag_we  = (r_state == S_CLR) || ((r_state == S_LOOK) && alloc);
        tgt_we  = (r_state == S_CLR) || ((r_state == S_CTR) && is_upd);
        hist_we = (r_state == S_CLR) ||
                  ((r_state == S_LOOK) && alloc && !i_cfg.global_history_on) ||
                  ((r_state == S_CTR) && is_upd && !i_cfg.global_history_on);
        hist_wd = (r_state == S_CTR) ? {r_e_hist[HIST_KEEP-2:0], r_it.taken} : '0;

        stor = (20'(5'(et) + 7'(TGT_BITS) + (i_cfg.global_history_on ? 7'd0 : 7'(h))) << k)
             + (i_cfg.global_history_on ? 20'(h) : 20'd0)
             + (i_cfg.global_table_on ? (20'd2 << h) : ((20'd2 << h) << k))
             + (20'd1 << k);
    end

    always_ff @(posedge i_clk) begin
        if (loc_we) m_loc[loc_addr] <= loc_wd;
        if (r_state == S_ADDR) r_loc_q <= m_loc[loc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) m_sh[sh_addr] <= sh_wd;
        if (r_state == S_ADDR) r_sh_q <= m_sh[sh_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tag_we)  m_tag[e_addr]  <= (r_state == S_CLR) ? '0 : r_it.tag;
        if (tgt_we)  m_tgt[e_addr]  <= (r_state == S_CLR) ? '0 : r_it.target;
        if (hist_we) m_hist[e_addr] <= hist_wd;
        if (o_pop) begin
            r_it      <= i_q_head;
            r_idx     <= head_idx;
            r_e_tag   <= m_tag[head_idx];
            r_e_tgt   <= m_tgt[head_idx];
            r_e_hist  <= m_hist[head_idx];
            r_e_valid <= r_valid[head_idx];
        end else if ((r_state == S_LOOK) && alloc && !i_cfg.global_history_on) begin
            r_e_hist <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sweep     <= '0;
            r_emit      <= 1'b0;
            r_valid     <= '0;
            r_sh_hist   <= '0;
            r_branches  <= '0;
            r_flushes   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (fin_go)            o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_valid    <= '0;
                    r_sh_hist  <= '0;
                    r_branches <= '0;
                    r_flushes  <= '0;
                    r_sweep    <= r_sweep + 1'b1;
                    if (sweep_end) r_state <= r_emit ? S_FIN : S_IDLE;
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_ptk <= 1'b0;
                        r_nf  <= '0;
                        r_fl  <= 1'b0;
                        unique case (i_q_head.mode)
                            MODE_CLEAR: begin
                                r_state <= S_CLR;
                                r_sweep <= '0;
                                r_emit  <= 1'b1;
                            end
                            MODE_PREDICT, MODE_UPDATE: r_state <= S_LOOK;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (alloc) r_valid[r_idx] <= 1'b1;
                    r_sweep <= '0;
                    r_state <= (alloc && !i_cfg.global_table_on) ? S_ALLOC : S_ADDR;
                end
                S_ALLOC: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (row_end) r_state <= S_ADDR;
                end
                S_ADDR: r_state <= S_CTR;
                S_CTR: begin
                    if (is_upd) begin
                        r_fl       <= fl;
                        r_branches <= r_branches + 32'd1;
                        if (fl) r_flushes <= r_flushes + 32'd1;
                        if (i_cfg.global_history_on)
                            r_sh_hist <= {r_sh_hist[HIST_KEEP-2:0], r_it.taken};
                    end else begin
                        r_ptk <= hit && ctr[1];
                        r_nf  <= (hit && ctr[1]) ? r_e_tgt : pc4;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: if (fin_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            o_predict_taken <= r_ptk;
            o_next_fetch    <= r_nf;
            o_flushed       <= r_fl;
            o_branch_count  <= r_branches;
            o_flush_count   <= r_flushes;
            o_storage_bits  <= stor[STOR_W-1:0];
        end
    end

    a_alloc_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ALLOC |-> r_it.mode == MODE_UPDATE && !i_cfg.global_table_on)
        else $error("row refill outside a local-table update");
    a_ctr_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CTR |=> r_state == S_FIN)
        else $error("counter step not followed by result");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CTR && r_it.mode == MODE_UPDATE |=>
        r_branches == $past(r_branches) + 32'd1)
        else $error("branch count did not advance on update");

endmodule

// ===== rtl/core/btb_two_level_branch_predictor.sv =====
// Top level of the two-level branch predictor with direct-mapped BTB.
// Holds the configuration registers; instantiates front, queue and back.
// Depends on btb2l_pkg, btb2l_front, btb2l_queue, btb2l_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries predict, update and clear
//   items; output channel (o_out_valid / i_out_stall) returns one result per
//   item, in order. A transfer happens when valid is high and stall is low.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
//   while the block is idle, a rule for the user that the block does not
//   enforce; registers act at once, state is rebuilt on clear. A predict or
//   update passes the lookup, counter address, counter step and finish states;
//   an allocating update with per-entry tables first refills its counter row;
//   a clear sweeps all 2^(IDX_W+MAX_HISTORY) local counter entries.
//   The back part takes a new item from the queue only once it is through with
//   the last, as the single-port counter memory is read and written back in
//   turn. Reset runs the same clearing sweep; input items queue in the
//   two-entry queue meanwhile and no result is produced for it. When the
//   receiver stalls, the result register holds; the back part finishes at most
//   one more item and waits, and the queue fills up to two.
module btb_two_level_branch_predictor import btb2l_pkg::*; #(
    parameter int BTB_DEPTH   = 32,
    parameter int MAX_HISTORY = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [PC_W-1:0]      i_branch_pc,
    input  logic [PC_W-1:0]      i_actual_target,
    input  logic                 i_was_taken,
    input  logic [PC_W-1:0]      i_predicted_dest,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_predict_taken,
    output logic [PC_W-1:0]      o_next_fetch,
    output logic                 o_flushed,
    output logic [PC_W-1:0]      o_branch_count,
    output logic [PC_W-1:0]      o_flush_count,
    output logic [STOR_W-1:0]    o_storage_bits
);
    localparam int K_MAX = $clog2(BTB_DEPTH + 1) - 1;

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item f_item;
    t_item q_head;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btb_size_log2     <= 3'd0;
            r_cfg.history_bits      <= 4'd1;
            r_cfg.tag_bits          <= 5'd0;
            r_cfg.counter_init      <= 2'd1;
            r_cfg.global_history_on <= 1'b0;
            r_cfg.global_table_on   <= 1'b0;
            r_cfg.share_mode        <= 2'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BTB_SIZE:  r_cfg.btb_size_log2     <= i_cfg_wdata[2:0];
                CFG_HIST_BITS: r_cfg.history_bits      <= i_cfg_wdata[3:0];
                CFG_TAG_BITS:  r_cfg.tag_bits          <= i_cfg_wdata[4:0];
                CFG_CTR_INIT:  r_cfg.counter_init      <= i_cfg_wdata[1:0];
                CFG_GLOB_HIST: r_cfg.global_history_on <= i_cfg_wdata[0];
                CFG_GLOB_TBL:  r_cfg.global_table_on   <= i_cfg_wdata[0];
                CFG_SHARE:     r_cfg.share_mode        <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // front: accept and tag items
    btb2l_front #(.K_MAX(K_MAX)) u_front (
        .i_valid          (i_in_valid),
        .i_mode           (i_mode),
        .i_branch_pc      (i_branch_pc),
        .i_actual_target  (i_actual_target),
        .i_was_taken      (i_was_taken),
        .i_predicted_dest (i_predicted_dest),
        .i_cfg            (r_cfg),
        .i_q_full         (q_full),
        .o_stall          (o_in_stall),
        .o_push           (push),
        .o_item           (f_item)
    );

    // decouple front from back
    btb2l_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: lookup, train, sweep and hold the result
    btb2l_back #(.BTB_DEPTH(BTB_DEPTH), .MAX_HISTORY(MAX_HISTORY)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (q_empty),
        .i_q_head        (q_head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_predict_taken (o_predict_taken),
        .o_next_fetch    (o_next_fetch),
        .o_flushed       (o_flushed),
        .o_branch_count  (o_branch_count),
        .o_flush_count   (o_flush_count),
        .o_storage_bits  (o_storage_bits)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for btb_two_level_branch_predictor.
// Drives predict, update and clear transfers and checks every result against
// an in-bench copy of the BTB and counter tables. Needs btb2l_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import btb2l_pkg::*;

    localparam int ENTRIES     = 32;
    localparam int ROW_LEN     = 256;
    localparam int IDLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 290;

    typedef struct {
        logic [1:0]      mode;
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] tgt;
        logic            taken;
        logic [PC_W-1:0] pdst;
    } t_branch_op;

    typedef struct {
        logic              ptaken;
        logic [PC_W-1:0]   next_fetch;
        logic              flushed;
        logic [PC_W-1:0]   branches;
        logic [PC_W-1:0]   flushes;
        logic [STOR_W-1:0] storage;
    } t_bp_result;

    typedef struct {
        t_branch_op op;
        bit         typed;
        t_bp_result res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_mode = MODE_PREDICT;
    logic [PC_W-1:0]      i_branch_pc = '0;
    logic [PC_W-1:0]      i_actual_target = '0;
    logic                 i_was_taken = 1'b0;
    logic [PC_W-1:0]      i_predicted_dest = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_predict_taken;
    logic [PC_W-1:0]      o_next_fetch;
    logic                 o_flushed;
    logic [PC_W-1:0]      o_branch_count;
    logic [PC_W-1:0]      o_flush_count;
    logic [STOR_W-1:0]    o_storage_bits;

    btb_two_level_branch_predictor dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow predictor: configuration and state, mirrored bit for bit
    // ---------------------------------------------------------------
    logic [2:0] sh_btb_log2;
    logic [3:0] sh_hist_bits;
    logic [4:0] sh_tag_bits;
    logic [1:0] sh_ctr_init;
    logic       sh_glob_hist;
    logic       sh_glob_tbl;
    logic [1:0] sh_share;

    logic            btb_valid [ENTRIES];
    logic [29:0]     btb_tag [ENTRIES];
    logic [PC_W-1:0] btb_target [ENTRIES];
    logic [7:0]      btb_hist [ENTRIES];
    logic [1:0]      row_ctr [ENTRIES][ROW_LEN];
    logic [1:0]      shared_ctr [ROW_LEN];
    logic [7:0]      path_hist;
    logic [PC_W-1:0] branches_total;
    logic [PC_W-1:0] flushes_total;

    t_bp_result pending_results[$];

    int unsigned err_count;
    int unsigned n_predict, n_update, n_clear, n_flush, n_checked;

    function automatic int unsigned idx_bits();
        return (sh_btb_log2 > 3'd5) ? 5 : sh_btb_log2;
    endfunction

    function automatic int unsigned hist_len();
        if (sh_hist_bits == 4'd0) return 1;
        if (sh_hist_bits > 4'd8) return 8;
        return sh_hist_bits;
    endfunction

    function automatic int unsigned tag_len();
        return (sh_tag_bits > 5'd30) ? 30 : sh_tag_bits;
    endfunction

    function automatic logic [1:0] share_sel();
        if (!sh_glob_tbl || sh_share > SHARE_MID) return SHARE_NONE;
        return sh_share;
    endfunction

    // counter row position picked by history, optionally hashed with the pc
    function automatic logic [7:0] ctr_slot(input int unsigned e, input logic [31:0] pc);
        logic [31:0] hv;
        hv = sh_glob_hist ? {24'd0, path_hist} : {24'd0, btb_hist[e]};
        if (share_sel() == SHARE_LOW) hv ^= pc >> 2;
        else if (share_sel() == SHARE_MID) hv ^= pc >> MID_SHIFT;
        return 8'(hv & ((32'd1 << hist_len()) - 1));
    endfunction

    function automatic logic [STOR_W-1:0] storage_size();
        int unsigned n, h, s;
        n = 1 << idx_bits();
        h = hist_len();
        s = n * (tag_len() + TGT_BITS + (sh_glob_hist ? 0 : h));
        s += sh_glob_hist ? h : 0;
        s += sh_glob_tbl ? (2 << h) : (2 << h) * n;
        s += n;
        return STOR_W'(s);
    endfunction

    function automatic void wipe_tables();
        for (int e = 0; e < ENTRIES; e++) begin
            btb_valid[e]  = 1'b0;
            btb_tag[e]    = '0;
            btb_target[e] = '0;
            btb_hist[e]   = '0;
            for (int j = 0; j < ROW_LEN; j++) row_ctr[e][j] = sh_ctr_init;
        end
        for (int j = 0; j < ROW_LEN; j++) shared_ctr[j] = sh_ctr_init;
        path_hist      = '0;
        branches_total = '0;
        flushes_total  = '0;
    endfunction

    function automatic t_bp_result predict_branch(input t_branch_op op);
        t_bp_result  r;
        int unsigned e;
        logic [29:0] tg;
        logic [7:0]  slot;
        logic        hit;
        r  = '{default: '0};
        e  = (op.pc >> 2) & ((1 << idx_bits()) - 1);
        tg = 30'((op.pc >> (2 + idx_bits())) & ((64'd1 << tag_len()) - 1));
        case (op.mode)
            MODE_PREDICT: begin
                hit  = btb_valid[e] && (tag_len() == 0 || btb_tag[e] == tg);
                slot = ctr_slot(e, op.pc);
                if (hit && (sh_glob_tbl ? shared_ctr[slot] : row_ctr[e][slot]) >= 2)
                    r.ptaken = 1'b1;
                r.next_fetch = r.ptaken ? btb_target[e] : op.pc + 32'd4;
                n_predict++;
            end
            MODE_UPDATE: begin
                if (!btb_valid[e] || btb_tag[e] != tg) begin
                    if (!sh_glob_tbl)
                        for (int j = 0; j < ROW_LEN; j++) row_ctr[e][j] = sh_ctr_init;
                    if (!sh_glob_hist) btb_hist[e] = '0;
                    btb_tag[e]   = tg;
                    btb_valid[e] = 1'b1;
                end
                r.flushed = op.taken ? (op.pdst != op.tgt) : (op.pdst != op.pc + 32'd4);
                slot = ctr_slot(e, op.pc);
                if (sh_glob_tbl) begin
                    if (op.taken && shared_ctr[slot] != 2'd3) shared_ctr[slot]++;
                    if (!op.taken && shared_ctr[slot] != 2'd0) shared_ctr[slot]--;
                end else begin
                    if (op.taken && row_ctr[e][slot] != 2'd3) row_ctr[e][slot]++;
                    if (!op.taken && row_ctr[e][slot] != 2'd0) row_ctr[e][slot]--;
                end
                if (sh_glob_hist) path_hist = {path_hist[6:0], op.taken};
                else btb_hist[e] = {btb_hist[e][6:0], op.taken};
                btb_target[e] = op.tgt;
                branches_total++;
                if (r.flushed) begin
                    flushes_total++;
                    n_flush++;
                end
                n_update++;
            end
            MODE_CLEAR: begin
                wipe_tables();
                n_clear++;
            end
            default: ;  // unused mode leaves state alone
        endcase
        r.branches = branches_total;
        r.flushes  = flushes_total;
        r.storage  = storage_size();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side: drive at the falling edge, hold until the transfer
    // ---------------------------------------------------------------
    task automatic send_branch(input t_branch_op op, input bit typed, input t_bp_result want);
        t_bp_result r;
        i_in_valid       <= 1'b1;
        i_mode           <= op.mode;
        i_branch_pc      <= op.pc;
        i_actual_target  <= op.tgt;
        i_was_taken      <= op.taken;
        i_predicted_dest <= op.pdst;
        #0.5;
        while (o_in_stall) begin
            @(negedge i_clk);
            #0.5;
        end
        @(negedge i_clk);
        r = predict_branch(op);
        pending_results.insert(pending_results.size(), typed ? want : r);
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
    endtask

    // write one register; only called while nothing is in flight,
    // the caller drops the enable after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        case (idx)
            CFG_BTB_SIZE:  sh_btb_log2  = val[2:0];
            CFG_HIST_BITS: sh_hist_bits = val[3:0];
            CFG_TAG_BITS:  sh_tag_bits  = val;
            CFG_CTR_INIT:  sh_ctr_init  = val[1:0];
            CFG_GLOB_HIST: sh_glob_hist = val[0];
            CFG_GLOB_TBL:  sh_glob_tbl  = val[0];
            CFG_SHARE:     sh_share     = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Output side: stall pattern, long hold-off, result check
    // ---------------------------------------------------------------
    bit          hold_go;
    int unsigned hold_left;
    bit          hold_taken;
    int unsigned cyc;
    int unsigned stall_pct;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(negedge i_clk) begin
        logic st;
        cyc++;
        if (cyc % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            st = 1'b1;
        end else begin
            st = ($urandom_range(0, 99) < stall_pct);
        end
        i_out_stall <= st;
    end

    // check each result at the rising edge that transfers it
    always @(posedge i_clk) begin
        t_bp_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report("result with nothing pending", 32'd0, 32'd0);
            end else begin
                w = pending_results.pop_front();
                n_checked++;
                if (o_predict_taken !== w.ptaken) report("predict_taken", o_predict_taken, w.ptaken);
                if (o_next_fetch !== w.next_fetch) report("next_fetch", o_next_fetch, w.next_fetch);
                if (o_flushed !== w.flushed) report("flushed", o_flushed, w.flushed);
                if (o_branch_count !== w.branches)
                    report("branch_count", o_branch_count, w.branches);
                if (o_flush_count !== w.flushes) report("flush_count", o_flush_count, w.flushes);
                if (o_storage_bits !== w.storage)
                    report("storage_bits", o_storage_bits, w.storage);
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    int unsigned quiet_cycles;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("btb_two_level_branch_predictor test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    t_dir_row dir_rows[$];

    function automatic void add_row(input logic [1:0] m, input logic [31:0] pc,
                                    input logic [31:0] tgt, input logic tk,
                                    input logic [31:0] pd, input bit typed,
                                    input logic [31:0] nf);
        t_dir_row d;
        d.op    = '{mode: m, pc: pc, tgt: tgt, taken: tk, pdst: pd};
        d.typed = typed;
        // typed rows: no prediction taken, no flush, counts at zero,
        // storage of the reset configuration (one entry, one history bit)
        d.res   = '{ptaken: 1'b0, next_fetch: nf, flushed: 1'b0,
                    branches: 32'd0, flushes: 32'd0, storage: 15'd36};
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    logic [31:0] pool_pc [8];
    logic [31:0] pool_tgt [8];

    function automatic t_branch_op random_branch();
        t_branch_op  op;
        int unsigned sel, p;
        sel = $urandom_range(0, 999);
        p   = $urandom_range(0, 7);
        op.pc    = ($urandom_range(0, 9) == 0) ? $urandom() : pool_pc[p];
        op.tgt   = ($urandom_range(0, 4) == 0) ? $urandom() : pool_tgt[p];
        op.taken = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2: op.pdst = $urandom();
            3:       op.pdst = op.taken ? op.pc + 32'd4 : op.tgt;
            default: op.pdst = op.taken ? op.tgt : op.pc + 32'd4;
        endcase
        if (sel < 3) op.mode = MODE_CLEAR;
        else if (sel < 15) op.mode = 2'd3;
        else if (sel < 470) op.mode = MODE_PREDICT;
        else op.mode = MODE_UPDATE;
        return op;
    endfunction

    // register settings per phase: size, history, tag, init, ghist, gtable, share
    logic [4:0] phase_cfg [6][7] = '{
        '{5'd5, 5'd8,  5'd30, 5'd3, 5'd0, 5'd0, 5'd0},
        '{5'd7, 5'd15, 5'd31, 5'd0, 5'd1, 5'd1, 5'd2},
        '{5'd2, 5'd4,  5'd6,  5'd2, 5'd1, 5'd1, 5'd1},
        '{5'd0, 5'd0,  5'd0,  5'd1, 5'd0, 5'd1, 5'd3},
        '{5'd3, 5'd3,  5'd10, 5'd1, 5'd0, 5'd1, 5'd2},
        '{5'd4, 5'd9,  5'd20, 5'd2, 5'd1, 5'd0, 5'd1}
    };

    initial begin
        t_branch_op  op;
        t_bp_result  nul;
        int unsigned burst;
        sh_btb_log2  = 3'd0;
        sh_hist_bits = 4'd1;
        sh_tag_bits  = 5'd0;
        sh_ctr_init  = 2'd1;
        sh_glob_hist = 1'b0;
        sh_glob_tbl  = 1'b0;
        sh_share     = SHARE_NONE;
        wipe_tables();
        nul = '{default: '0};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part under the reset configuration
        add_row(MODE_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0, 1, 32'h0000_0004);
        add_row(MODE_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0, 1, 32'h0000_0000);
        add_row(MODE_UPDATE,  32'h0000_0040, 32'h0000_1000, 1'b1, 32'h0000_1000, 0, 0);
        add_row(MODE_UPDATE,  32'h0000_0040, 32'h0000_1000, 1'b1, 32'h0000_0000, 0, 0);
        add_row(MODE_PREDICT, 32'h0000_0040, 32'h0, 1'b0, 32'h0, 0, 0);
        add_row(MODE_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0003, 0, 0);
        add_row(MODE_UPDATE,  32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 0, 0);
        add_row(MODE_UPDATE,  32'hFFFF_FFFC, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 0, 0);
        add_row(MODE_PREDICT, 32'h1234_5678, 32'h0, 1'b0, 32'h0, 0, 0);
        add_row(2'd3,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0, 0);
        add_row(MODE_UPDATE,  32'h0000_0080, 32'h5555_5555, 1'b1, 32'h5555_5555, 0, 0);
        add_row(MODE_UPDATE,  32'h0000_0080, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 0, 0);
        add_row(MODE_PREDICT, 32'h0000_0080, 32'h0, 1'b0, 32'h0, 0, 0);
        add_row(MODE_CLEAR,   32'h0000_0080, 32'h0, 1'b0, 32'h0, 1, 32'h0);
        add_row(MODE_PREDICT, 32'h0000_0040, 32'h0, 1'b0, 32'h0, 1, 32'h0000_0044);
        foreach (dir_rows[i]) send_branch(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
        drop_valid();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 7; r++) write_reg(CFG_IDX_W'(r), phase_cfg[ph][r]);
            i_cfg_wr_en <= 1'b0;
            foreach (pool_pc[i]) begin
                pool_pc[i]  = $urandom();
                pool_tgt[i] = $urandom();
            end
            op = '{mode: MODE_CLEAR, pc: '0, tgt: '0, taken: 1'b0, pdst: '0};
            send_branch(op, 0, nul);
            for (int n = 0; n < PHASE_ITEMS; ) begin
                // burst of back-to-back transfers, then an idle gap in three of four cases
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && n < PHASE_ITEMS; b++, n++) begin
                    send_branch(random_branch(), 0, nul);
                    if (ph == 1 && n == 100) hold_go = 1'b1;
                end
                if ($urandom_range(0, 3) != 0) begin
                    drop_valid();
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
            drop_valid();
            drain();
        end

        $display("covered %0d predicts, %0d updates (%0d flushes), %0d clears over 6 settings",
                 n_predict, n_update, n_flush, n_clear);
        $display("checked %0d results, %0d mismatches", n_checked, err_count);
        if (err_count == 0)
            $display("btb_two_level_branch_predictor test passed");
        else
            $display("btb_two_level_branch_predictor test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/btb2l_pkg.sv
rtl/core/btb2l_front.sv
rtl/core/btb2l_queue.sv
rtl/core/btb2l_back.sv
rtl/core/btb_two_level_branch_predictor.sv
bench/testbench.sv
